[rtl/shared_pool_multi_stack_defines.svh]
// assertion macros for the shared pool multi-stack block
// used by shared_pool_multi_stack.sv; expects clk and rst_n in the including scope
`ifndef SHARED_POOL_MULTI_STACK_DEFINES_SVH
`define SHARED_POOL_MULTI_STACK_DEFINES_SVH
`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define SPMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// condition implies consequence in the next cycle
`define SPMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPMS_ASSERT_SAME(lbl, ante, cons, msg)
`define SPMS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/spms_pkg.sv]
// shared types and codes for the shared pool multi-stack block
// no dependencies; used by the top level

package spms_pkg;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // one request transfer
  typedef struct packed {
    logic               cmd;
    logic [1:0]         stack_id;
    logic signed [31:0] push_value;
  } spms_in_t;

  // one result transfer
  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
  } spms_out_t;

endpackage

[rtl/spms_entry_ram.sv]
// single-port-write, single-port-read entry memory with registered read data
// no dependencies; holds the value and link of every pool entry

module spms_entry_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 39
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/spms_free_finder.sv]
// two-level search for the lowest free pool entry at or above a start index
// no dependencies; groups of eight are encoded and registered, then a final
// priority pick over the group results gives the index in the following cycle

module spms_free_finder #(
  parameter int POOL_DEPTH = 128
) (
  input  logic                          clk,
  input  logic [POOL_DEPTH-1:0]         used,
  input  logic [$clog2(POOL_DEPTH)-1:0] start_idx,
  output logic                          found,
  output logic [$clog2(POOL_DEPTH)-1:0] found_idx
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int GRP   = 8;
  localparam int OFF_W = $clog2(GRP);
  localparam int NGRP  = (POOL_DEPTH + GRP - 1) / GRP;
  localparam int PAD_W = NGRP * GRP;

  logic [PAD_W-1:0] used_pad;
  logic [PAD_W-1:0] free_vec;
  logic [NGRP-1:0]  grp_any_nxt;
  logic [OFF_W-1:0] grp_off_nxt [NGRP];
  logic [NGRP-1:0]  grp_any_r;
  logic [OFF_W-1:0] grp_off_r [NGRP];

  // free and at or above the start, padding counts as used
  always_comb begin
    used_pad = '1;
    used_pad[POOL_DEPTH-1:0] = used;
    for (int b = 0; b < PAD_W; b++) begin
      free_vec[b] = !used_pad[b] && (b >= int'(start_idx));
    end
  end

  // first free bit inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_off_nxt[g] = '0;
      for (int k = GRP - 1; k >= 0; k--) begin
        if (free_vec[g * GRP + k]) begin
          grp_any_nxt[g] = 1'b1;
          grp_off_nxt[g] = OFF_W'(k);
        end
      end
    end
  end

  // group stage register
  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    for (int g = 0; g < NGRP; g++) begin
      grp_off_r[g] <= grp_off_nxt[g];
    end
  end

  // lowest group with a free entry
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found     = 1'b1;
        found_idx = IDX_W'(g * GRP + int'(grp_off_r[g]));
      end
    end
  end

endmodule

[rtl/shared_pool_multi_stack.sv]
// top level: several stacks linked through one shared entry pool
// depends on spms_pkg, spms_entry_ram, spms_free_finder and the defines header
// channel  | ports                    | direction | transfer when
// request  | start, busy, in_data     | in        | start high and busy low
// result   | out_valid, out_data      | out       | out_valid high, one cycle
// Push: bitmap group stage (S_SCAN), then final pick and write (S_FIND).
// Pop: read issue (S_READ), read data and write back of used bit and top (S_POP).
// Bad stack id or pop on an empty stack: result in the cycle after accept.
// Reset (rst_n low, synchronous) frees every entry and empties every stack at
// once through flip-flop used bits; no clearing pass. Results cannot be stalled.

`include "shared_pool_multi_stack_defines.svh"

module shared_pool_multi_stack #(
  parameter int POOL_DEPTH = 128,
  parameter int NUM_STACKS = 3,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  spms_pkg::spms_in_t  in_data,
  output logic                out_valid,
  output spms_pkg::spms_out_t out_data
);

  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int WORD_W = IDX_W + DATA_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIND,
    S_READ,
    S_POP
  } state_t;

  state_t                  state_r;
  logic [POOL_DEPTH-1:0]   used_r;
  logic [IDX_W-1:0]        top_r [NUM_STACKS];
  logic [NUM_STACKS-1:0]   filled_r;
  logic [1:0]              sid_r;
  logic signed [31:0]      val_r;
  logic                    out_valid_r;
  spms_pkg::spms_out_t     out_data_r;

  logic                    in_sid_ok;
  logic                    in_filled;
  logic [IDX_W-1:0]        cur_top;
  logic                    cur_filled;
  logic [IDX_W-1:0]        scan_start;
  logic                    fnd_found;
  logic [IDX_W-1:0]        fnd_idx;
  logic                    ram_we;
  logic                    ram_re;
  logic [WORD_W-1:0]       ram_wdata;
  logic [WORD_W-1:0]       ram_rdata;
  logic [DATA_WIDTH-1:0]   store_val;
  logic [IDX_W-1:0]        new_link;
  logic [IDX_W-1:0]        rd_link;
  logic [DATA_WIDTH-1:0]   rd_val;
  logic [31:0]             pop_ext;

  // stack lookups for the incoming and the latched request
  always_comb begin
    in_sid_ok  = 1'b0;
    in_filled  = 1'b0;
    cur_top    = '0;
    cur_filled = 1'b0;
    for (int s = 0; s < NUM_STACKS; s++) begin
      if (int'(in_data.stack_id) == s) begin
        in_sid_ok = 1'b1;
        in_filled = filled_r[s];
      end
      if (int'(sid_r) == s) begin
        cur_top    = top_r[s];
        cur_filled = filled_r[s];
      end
    end
  end

  assign scan_start = cur_filled ? cur_top : '0;

  // free entry search
  spms_free_finder #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_finder (
    .clk       (clk),
    .used      (used_r),
    .start_idx (scan_start),
    .found     (fnd_found),
    .found_idx (fnd_idx)
  );

  // stored width and pop sign extension
  always_comb begin
    for (int b = 0; b < DATA_WIDTH; b++) begin
      store_val[b] = val_r[(b < 32) ? b : 31];
    end
    rd_val  = ram_rdata[DATA_WIDTH-1:0];
    rd_link = ram_rdata[WORD_W-1:DATA_WIDTH];
    for (int b = 0; b < 32; b++) begin
      pop_ext[b] = rd_val[(b < DATA_WIDTH) ? b : DATA_WIDTH - 1];
    end
  end

  // memory access
  assign new_link  = cur_filled ? cur_top : fnd_idx;
  assign ram_we    = (state_r == S_FIND) && fnd_found;
  assign ram_wdata = {new_link, store_val};
  assign ram_re    = (state_r == S_READ);

  spms_entry_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (fnd_idx),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (cur_top),
    .rd_data (ram_rdata)
  );

  // sequencer, stack state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_STACKS; s++) begin
        top_r[s] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            sid_r <= in_data.stack_id;
            val_r <= in_data.push_value;
            if (in_data.cmd == spms_pkg::CMD_PUSH) begin
              if (in_sid_ok) begin
                state_r <= S_SCAN;
              end else begin
                out_valid_r          <= 1'b1;
                out_data_r.pop_value <= '0;
                out_data_r.status    <= spms_pkg::ST_FULL;
              end
            end else begin
              if (in_sid_ok && in_filled) begin
                state_r <= S_READ;
              end else begin
                out_valid_r          <= 1'b1;
                out_data_r.pop_value <= '0;
                out_data_r.status    <= spms_pkg::ST_EMPTY;
              end
            end
          end
        end
        S_SCAN: begin
          state_r <= S_FIND;
        end
        S_FIND: begin
          state_r              <= S_IDLE;
          out_valid_r          <= 1'b1;
          out_data_r.pop_value <= '0;
          if (fnd_found) begin
            out_data_r.status <= spms_pkg::ST_OK;
            used_r[fnd_idx]   <= 1'b1;
            for (int s = 0; s < NUM_STACKS; s++) begin
              if (int'(sid_r) == s) begin
                top_r[s]    <= fnd_idx;
                filled_r[s] <= 1'b1;
              end
            end
          end else begin
            out_data_r.status <= spms_pkg::ST_FULL;
          end
        end
        S_READ: begin
          state_r <= S_POP;
        end
        S_POP: begin
          state_r              <= S_IDLE;
          out_valid_r          <= 1'b1;
          out_data_r.pop_value <= pop_ext;
          out_data_r.status    <= spms_pkg::ST_OK;
          used_r[cur_top]      <= 1'b0;
          for (int s = 0; s < NUM_STACKS; s++) begin
            if (int'(sid_r) == s) begin
              if (rd_link == cur_top) begin
                top_r[s]    <= '0;
                filled_r[s] <= 1'b0;
              end else begin
                top_r[s] <= rd_link;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `SPMS_ASSERT_SAME(a_done_strobe, $fell(busy), out_valid, "operation ended without a result")
  `SPMS_ASSERT_SAME(a_take_free, ram_we, !used_r[fnd_idx], "push would take a used entry")
  `SPMS_ASSERT_SAME(a_pop_filled, state_r == S_POP, cur_filled, "pop on an empty stack")
  `SPMS_ASSERT_NEXT(a_pop_frees, state_r == S_POP, !used_r[$past(cur_top)], "pop kept entry")
  `SPMS_ASSERT_SAME(a_fail_zero, out_valid && (out_data.status != spms_pkg::ST_OK),
                    out_data.pop_value == 32'sd0, "failed operation with nonzero value")

endmodule

[sim/spms_checker.sv]
// result checker for the shared pool multi-stack block: tracks pool and stacks,
// predicts each result, compares it with what the block returns
// depends on spms_pkg; instantiated by shared_pool_multi_stack_tb

module spms_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  spms_pkg::spms_in_t  in_data,
  input  logic                out_valid,
  input  spms_pkg::spms_out_t out_data,
  output int                  pending,
  output int                  fail_count
);

  localparam int POOL_DEPTH = 128;
  localparam int NUM_STACKS = 3;

  // shadow copy of the pool and the per-stack top pointers
  logic [31:0] pool_value [POOL_DEPTH];
  int          pool_link  [POOL_DEPTH];
  bit          slot_used  [POOL_DEPTH];
  int          stack_top  [NUM_STACKS];
  bit          stack_live [NUM_STACKS];

  spms_pkg::spms_out_t expected_results[$];
  int                  n_fail = 0;

  assign fail_count = n_fail;

  // apply one push or pop to the shadow state and return its result
  function automatic spms_pkg::spms_out_t predict_stack_op(spms_pkg::spms_in_t op);
    spms_pkg::spms_out_t res;
    int                  sid;
    int                  first;
    int                  slot;
    int                  below;
    bit                  placed;
    res    = '0;
    sid    = op.stack_id;
    placed = 1'b0;
    if (op.cmd == spms_pkg::CMD_PUSH) begin
      res.status = spms_pkg::ST_FULL;
      if (sid < NUM_STACKS) begin
        // lowest free entry at or above the top, or from entry 0 when empty
        first = stack_live[sid] ? stack_top[sid] : 0;
        for (int i = first; i < POOL_DEPTH && !placed; i++) begin
          if (!slot_used[i]) begin
            pool_value[i]   = op.push_value;
            pool_link[i]    = stack_live[sid] ? stack_top[sid] : i;
            slot_used[i]    = 1'b1;
            stack_top[sid]  = i;
            stack_live[sid] = 1'b1;
            res.status      = spms_pkg::ST_OK;
            placed          = 1'b1;
          end
        end
      end
    end else begin
      res.status = spms_pkg::ST_EMPTY;
      if (sid < NUM_STACKS && stack_live[sid]) begin
        slot          = stack_top[sid];
        below         = pool_link[slot];
        res.pop_value = pool_value[slot];
        res.status    = spms_pkg::ST_OK;
        slot_used[slot] = 1'b0;
        // bottom entry links to itself: stack goes empty
        if (below == slot) begin
          stack_live[sid] = 1'b0;
          stack_top[sid]  = 0;
        end else begin
          stack_top[sid] = below;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    spms_pkg::spms_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < POOL_DEPTH; i++) slot_used[i] = 1'b0;
      for (int s = 0; s < NUM_STACKS; s++) begin
        stack_live[s] = 1'b0;
        stack_top[s]  = 0;
      end
      expected_results.delete();
    end else begin
      // result transfer against the oldest expectation
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result pop_value %0d status %0d", $time,
                   out_data.pop_value, out_data.status);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.pop_value !== want.pop_value)
            $display("%0t: pop_value expected %0d actual %0d", $time,
                     want.pop_value, out_data.pop_value);
          if (out_data.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_data.status);
          if (out_data !== want) n_fail++;
        end
      end
      // request transfer
      if (start && !busy) expected_results.push_back(predict_stack_op(in_data));
    end
    // results still owed by the block
    pending = expected_results.size();
  end

endmodule

[sim/shared_pool_multi_stack_tb.sv]
// testbench top for the shared pool multi-stack block: clock, reset, stimulus
// and verdict; depends on spms_pkg, spms_checker and shared_pool_multi_stack

module shared_pool_multi_stack_tb;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  spms_pkg::spms_in_t  in_data = '0;
  logic                busy;
  logic                out_valid;
  spms_pkg::spms_out_t out_data;
  int                  pending;
  int                  fail_count;
  bit                  use_gaps = 1'b1;

  shared_pool_multi_stack i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  spms_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!use_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // random word, with the extremes mixed in
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // one request transfer, preceded by a random gap
  task automatic issue_op(input logic cmd, input logic [1:0] sid, input logic [31:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start              <= 1'b1;
    in_data.cmd        <= cmd;
    in_data.stack_id   <= sid;
    in_data.push_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold requests until every result is back
  task automatic wait_drain();
    @(negedge clk) start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int push_pct;
    int len;
    int phase;
    int random_sent;
    logic cmd;
    logic [1:0] sid;

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: extremes, interleaved stacks, bad ids, pops on empty stacks
    issue_op(spms_pkg::CMD_PUSH, 2'd0, 32'h7fff_ffff);
    issue_op(spms_pkg::CMD_PUSH, 2'd0, 32'h8000_0000);
    issue_op(spms_pkg::CMD_PUSH, 2'd1, 32'hffff_ffff);
    issue_op(spms_pkg::CMD_PUSH, 2'd2, 32'h0000_0000);
    issue_op(spms_pkg::CMD_PUSH, 2'd1, 32'h5555_5555);
    issue_op(spms_pkg::CMD_PUSH, 2'd2, 32'haaaa_aaaa);
    issue_op(spms_pkg::CMD_PUSH, 2'd3, 32'h1234_5678);
    issue_op(spms_pkg::CMD_POP,  2'd3, 32'hffff_ffff);
    issue_op(spms_pkg::CMD_POP,  2'd0, 32'h0);
    issue_op(spms_pkg::CMD_POP,  2'd0, 32'h0);
    issue_op(spms_pkg::CMD_POP,  2'd0, 32'h0);
    issue_op(spms_pkg::CMD_POP,  2'd1, 32'h0);
    issue_op(spms_pkg::CMD_POP,  2'd1, 32'h0);
    issue_op(spms_pkg::CMD_POP,  2'd1, 32'h0);
    issue_op(spms_pkg::CMD_POP,  2'd2, 32'h0);
    issue_op(spms_pkg::CMD_POP,  2'd2, 32'h0);
    issue_op(spms_pkg::CMD_POP,  2'd2, 32'h0);
    issue_op(spms_pkg::CMD_PUSH, 2'd1, 32'h0000_0011);
    issue_op(spms_pkg::CMD_PUSH, 2'd0, 32'h0000_0022);
    issue_op(spms_pkg::CMD_PUSH, 2'd1, 32'h0000_0033);
    issue_op(spms_pkg::CMD_POP,  2'd1, 32'h0);
    issue_op(spms_pkg::CMD_POP,  2'd1, 32'h0);
    issue_op(spms_pkg::CMD_POP,  2'd0, 32'h0);
    wait_drain();

    // random phases: fill to full, drain to empty, then mixed push ratios
    random_sent = 0;
    phase       = 0;
    while (random_sent < 927) begin
      if (phase == 0) begin
        push_pct = 95;
        len      = 220;
      end else if (phase == 1) begin
        push_pct = 5;
        len      = 200;
      end else begin
        push_pct = $urandom_range(10, 90);
        len      = $urandom_range(30, 120);
      end
      use_gaps = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len && random_sent < 927; k++) begin
        cmd = ($urandom_range(0, 99) < push_pct) ? spms_pkg::CMD_PUSH : spms_pkg::CMD_POP;
        sid = ($urandom_range(0, 99) < 6) ? 2'd3 : 2'($urandom_range(0, 2));
        issue_op(cmd, sid, pick_value());
        random_sent++;
      end
      if ($urandom_range(0, 1) == 1) wait_drain();
      phase++;
    end

    // let the last results come back, then a few quiet cycles
    wait_drain();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/spms_pkg.sv
rtl/spms_entry_ram.sv
rtl/spms_free_finder.sv
rtl/shared_pool_multi_stack.sv
sim/spms_checker.sv
sim/shared_pool_multi_stack_tb.sv
